FILE: rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, phase codes, byte kinds and status codes for the
// configuration-file section parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // transfer payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bsp_in_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_kind;
        logic [2:0]  section_index;
        logic [31:0] payload_length;
        logic [2:0]  parse_status;
    } bsp_out_t;

    // parser phases
    localparam logic [2:0] PH_PRE   = 3'd0;
    localparam logic [2:0] PH_TAG   = 3'd1;
    localparam logic [2:0] PH_SLEN  = 3'd2;
    localparam logic [2:0] PH_TEXT  = 3'd3;
    localparam logic [2:0] PH_PLEN  = 3'd4;
    localparam logic [2:0] PH_PAY   = 3'd5;
    localparam logic [2:0] PH_TRAIL = 3'd6;
    localparam logic [2:0] PH_IGN   = 3'd7;

    // byte kinds
    localparam logic [2:0] KIND_PREAMBLE = 3'd0;
    localparam logic [2:0] KIND_TAG      = 3'd1;
    localparam logic [2:0] KIND_SLEN     = 3'd2;
    localparam logic [2:0] KIND_TEXT     = 3'd3;
    localparam logic [2:0] KIND_PLEN     = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd5;
    localparam logic [2:0] KIND_TRAILING = 3'd6;
    localparam logic [2:0] KIND_IGNORED  = 3'd7;

    // parse status codes
    localparam logic [2:0] STATUS_RUNNING      = 3'd0;
    localparam logic [2:0] STATUS_DONE_OK      = 3'd1;
    localparam logic [2:0] STATUS_DONE_TRAIL   = 3'd2;
    localparam logic [2:0] STATUS_BAD_PREAMBLE = 3'd3;
    localparam logic [2:0] STATUS_BAD_SECTION  = 3'd4;
    localparam logic [2:0] STATUS_EARLY_END    = 3'd5;
    localparam logic [2:0] STATUS_SECT_OVERRUN = 3'd6;
    localparam logic [2:0] STATUS_PAY_OVERRUN  = 3'd7;

    // section tags and field sizes
    localparam logic [7:0] TAG_A          = 8'h61;
    localparam logic [7:0] TAG_D          = 8'h64;
    localparam logic [7:0] TAG_E          = 8'h65;
    localparam logic [2:0] SECTION_E      = 3'd4;
    localparam logic [3:0] PREAMBLE_LEN   = 4'd13;
    localparam logic [2:0] SLEN_BYTES     = 3'd2;
    localparam logic [2:0] PLEN_BYTES     = 3'd4;

    // parser state
    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  preamble_position;
        logic [2:0]  current_section;
        logic [31:0] length_accumulator;
        logic [31:0] bytes_remaining;
        logic [2:0]  field_byte_count;
        logic [2:0]  latched_error;
        logic [31:0] saved_payload_length;
    } bsp_state_t;

    localparam bsp_state_t STATE_RESET = '{
        phase:                PH_PRE,
        preamble_position:    4'd0,
        current_section:      3'd0,
        length_accumulator:   32'd0,
        bytes_remaining:      32'd0,
        field_byte_count:     3'd0,
        latched_error:        STATUS_RUNNING,
        saved_payload_length: 32'd0
    };

    // fixed file preamble 00 09 0f f0 0f f0 0f f0 0f f0 00 00 01
    function automatic logic [7:0] preamble_byte(input logic [3:0] pos);
        logic [7:0] val;
        unique case (pos)
            4'd1:                      val = 8'h09;
            4'd2, 4'd4, 4'd6, 4'd8:    val = 8'h0f;
            4'd3, 4'd5, 4'd7, 4'd9:    val = 8'hf0;
            4'd12:                     val = 8'h01;
            default:                   val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/bsp_step.sv
// ----------------------------------------------------------------------------
// bsp_step
// Per-byte next-state and result logic of the section parser.
// ----------------------------------------------------------------------------
module bsp_step (
    input  bsp_pkg::bsp_state_t state,
    input  bsp_pkg::bsp_in_t    item,
    output bsp_pkg::bsp_state_t state_next,
    output bsp_pkg::bsp_out_t   result
);
    import bsp_pkg::*;

    bsp_state_t  upd;
    logic [2:0]  kind;
    logic [2:0]  err;
    logic [2:0]  end_code;
    logic [2:0]  status;
    logic [31:0] acc_shift;
    logic [2:0]  cnt_inc;
    logic [31:0] rem_dec;
    logic [7:0]  tag_off;
    logic [3:0]  pos_inc;

    always_comb
    begin
        upd       = state;
        kind      = KIND_IGNORED;
        err       = STATUS_RUNNING;
        acc_shift = {state.length_accumulator[23:0], item.data_byte};
        cnt_inc   = state.field_byte_count + 3'd1;
        rem_dec   = (state.bytes_remaining != 32'd0) ?
                    state.bytes_remaining - 32'd1 : state.bytes_remaining;
        tag_off   = item.data_byte - TAG_A;
        pos_inc   = state.preamble_position + 4'd1;

        unique case (state.phase)
            PH_PRE:
            begin
                kind = KIND_PREAMBLE;
                if (state.preamble_position >= PREAMBLE_LEN ||
                    item.data_byte != preamble_byte(state.preamble_position))
                begin
                    err = STATUS_BAD_PREAMBLE;
                end
                else
                begin
                    upd.preamble_position = pos_inc;
                    if (pos_inc == PREAMBLE_LEN)
                    begin
                        upd.phase = PH_TAG;
                    end
                end
            end
            PH_TAG:
            begin
                kind = KIND_TAG;
                if (item.data_byte == TAG_E)
                begin
                    upd.current_section    = SECTION_E;
                    upd.phase              = PH_PLEN;
                    upd.field_byte_count   = 3'd0;
                    upd.length_accumulator = 32'd0;
                end
                else if (item.data_byte >= TAG_A && item.data_byte <= TAG_D)
                begin
                    upd.current_section    = tag_off[2:0];
                    upd.phase              = PH_SLEN;
                    upd.field_byte_count   = 3'd0;
                    upd.length_accumulator = 32'd0;
                end
                else
                begin
                    err = STATUS_BAD_SECTION;
                end
            end
            PH_SLEN:
            begin
                kind = KIND_SLEN;
                upd.length_accumulator = acc_shift;
                upd.field_byte_count   = cnt_inc;
                if (cnt_inc >= SLEN_BYTES)
                begin
                    upd.bytes_remaining = {16'd0, acc_shift[15:0]};
                    upd.phase = (acc_shift[15:0] != 16'd0) ? PH_TEXT : PH_TAG;
                end
            end
            PH_TEXT:
            begin
                kind = KIND_TEXT;
                upd.bytes_remaining = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    upd.phase = PH_TAG;
                end
            end
            PH_PLEN:
            begin
                kind = KIND_PLEN;
                upd.length_accumulator = acc_shift;
                upd.field_byte_count   = cnt_inc;
                if (cnt_inc >= PLEN_BYTES)
                begin
                    upd.saved_payload_length = acc_shift;
                    upd.bytes_remaining      = acc_shift;
                    upd.phase = (acc_shift != 32'd0) ? PH_PAY : PH_TRAIL;
                end
            end
            PH_PAY:
            begin
                kind = KIND_PAYLOAD;
                upd.bytes_remaining = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    upd.phase = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                kind = KIND_TRAILING;
            end
            PH_IGN:
            begin
                kind = KIND_IGNORED;
            end
        endcase

        if (err != STATUS_RUNNING)
        begin
            upd.latched_error = err;
            upd.phase         = PH_IGN;
        end

        // status if the file ends here
        unique case (upd.phase)
            PH_PRE:   end_code = STATUS_BAD_PREAMBLE;
            PH_TEXT:  end_code = STATUS_SECT_OVERRUN;
            PH_PAY:   end_code = STATUS_PAY_OVERRUN;
            PH_TRAIL: end_code = (kind == KIND_TRAILING) ?
                                 STATUS_DONE_TRAIL : STATUS_DONE_OK;
            default:  end_code = STATUS_EARLY_END;
        endcase

        priority if (upd.latched_error != STATUS_RUNNING)
        begin
            status = upd.latched_error;
        end
        else if (item.last_byte)
        begin
            status = end_code;
        end
        else
        begin
            status = STATUS_RUNNING;
        end

        result.byte_out       = item.data_byte;
        result.byte_kind      = kind;
        result.section_index  = upd.current_section;
        result.payload_length = upd.saved_payload_length;
        result.parse_status   = status;

        // last byte re-arms for the next file
        state_next = item.last_byte ? STATE_RESET : upd;
    end

endmodule

FILE: rtl/bitfile_section_parser_top.sv
// ----------------------------------------------------------------------------
// bitfile_section_parser_top
// Streaming header parser for FPGA configuration files: checks the preamble,
// walks sections a..e, tags each byte and passes it through.
// ----------------------------------------------------------------------------
// While item_stall is low, one byte is taken per clock and yields exactly
// one result transfer in the cycle after, so sustained throughput is one
// byte per cycle. The parser state and the result register update in the
// same edge from a combinational compare/shift/decrement step. item_stall
// is raised only while a result is held and result_stall is high. Errors
// are latched: after one, every byte up to the last of the file is marked
// ignored. The byte flagged last_byte resets the parser for the next file.
module bitfile_section_parser_top (
    input  logic              clk,
    input  logic              rst_n,
    // input byte transfers
    input  logic              item_valid,
    output logic              item_stall,
    input  bsp_pkg::bsp_in_t  item,
    // tagged byte transfers
    output logic              result_valid,
    input  logic              result_stall,
    output bsp_pkg::bsp_out_t result
);
    import bsp_pkg::*;

    bsp_state_t state_reg;
    bsp_state_t state_next;
    bsp_out_t   result_reg;
    bsp_out_t   result_next;
    logic       result_valid_reg;
    logic       accept;

    // the result register frees up in the same cycle it is taken
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    // per-byte parsing step
    bsp_step u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every accepted byte leaves a result behind
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg
    ) else $error("accepted byte produced no result");

    // last byte returns the parser to its start
    a_last_rearms: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && item.last_byte) |=>
            (state_reg.phase == PH_PRE && state_reg.latched_error == STATUS_RUNNING &&
             state_reg.preamble_position == 4'd0)
    ) else $error("parser not re-armed after last byte");

    // a latched error always parks the parser in the ignore phase
    a_error_parks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg.latched_error != STATUS_RUNNING) |-> (state_reg.phase == PH_IGN)
    ) else $error("latched error outside ignore phase");

    // text and payload phases always have bytes left to count
    a_count_live: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_TEXT || state_reg.phase == PH_PAY) |->
            (state_reg.bytes_remaining != 32'd0)
    ) else $error("empty byte count inside text or payload");

    // preamble position never runs past the fixed preamble
    a_preamble_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PRE) |-> (state_reg.preamble_position < PREAMBLE_LEN)
    ) else $error("preamble position out of range");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the configuration-file section parser. Streams
// whole files (intact, cut short, with a bad preamble or tag, plain noise)
// through the byte channel and checks every tagged byte against a
// cycle-free predictor of the parser, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import bsp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    // rough byte budget for the random files
    localparam int RANDOM_BYTES  = 1850;
    // let the last result drain through the parser, plus margin
    localparam int SETTLE_CYCLES = 10;
    // cycles with no transfer on either side before the run is abandoned
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 50;

    // file preamble 00 09 0f f0 0f f0 0f f0 0f f0 00 00 01, element 0 first
    localparam logic [12:0][7:0] FILE_PREAMBLE = {
        8'h01, 8'h00, 8'h00, 8'hf0, 8'h0f, 8'hf0, 8'h0f,
        8'hf0, 8'h0f, 8'hf0, 8'h0f, 8'h09, 8'h00
    };

    // every input starts at a known value
    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_stall;
    bsp_in_t  item         = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    bsp_out_t result;

    // bytes waiting to be sent, and tagged bytes still owed by the parser
    bsp_in_t     file_bytes_pending[$];
    bsp_out_t    tagged_bytes_due[$];
    int unsigned bytes_queued   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // idling: per-transfer waits, with stretches of back-to-back traffic
    int unsigned send_wait   = 0;
    int unsigned take_wait   = 0;
    logic        send_steady = 1'b0;
    logic        take_steady = 1'b0;

    // predictor copy of the parser state
    logic [2:0]  p_phase;
    logic [3:0]  p_pre_pos;
    logic [2:0]  p_section;
    logic [31:0] p_acc;
    logic [31:0] p_remaining;
    logic [2:0]  p_count;
    logic [2:0]  p_error;
    logic [31:0] p_saved;

    bitfile_section_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // back to the state after reset; the parser also does this after a last byte
    task automatic clear_parse_state();
        p_phase     = PH_PRE;
        p_pre_pos   = '0;
        p_section   = '0;
        p_acc       = '0;
        p_remaining = '0;
        p_count     = '0;
        p_error     = STATUS_RUNNING;
        p_saved     = '0;
    endtask

    // tag one byte and advance the predicted parser state
    task automatic tag_byte(input bsp_in_t in, output bsp_out_t res);
        logic [7:0] b;
        logic [2:0] kind;
        logic [2:0] err;
        logic [2:0] status;
        b    = in.data_byte;
        kind = KIND_IGNORED;
        err  = STATUS_RUNNING;
        case (p_phase)
            PH_PRE:
            begin
                kind = KIND_PREAMBLE;
                if (p_pre_pos >= PREAMBLE_LEN || b != FILE_PREAMBLE[p_pre_pos])
                    err = STATUS_BAD_PREAMBLE;
                else
                begin
                    p_pre_pos = p_pre_pos + 1'b1;
                    if (p_pre_pos == PREAMBLE_LEN)
                        p_phase = PH_TAG;
                end
            end
            PH_TAG:
            begin
                kind = KIND_TAG;
                if (b == TAG_E)
                begin
                    p_section = SECTION_E;
                    p_phase   = PH_PLEN;
                    p_count   = '0;
                    p_acc     = '0;
                end
                else if (b >= TAG_A && b <= TAG_D)
                begin
                    p_section = 3'(b - TAG_A);
                    p_phase   = PH_SLEN;
                    p_count   = '0;
                    p_acc     = '0;
                end
                else
                    err = STATUS_BAD_SECTION;
            end
            PH_SLEN:
            begin
                kind    = KIND_SLEN;
                p_acc   = {p_acc[23:0], b};
                p_count = p_count + 1'b1;
                if (p_count >= SLEN_BYTES)
                begin
                    p_remaining = {16'd0, p_acc[15:0]};
                    p_phase     = (p_remaining != 0) ? PH_TEXT : PH_TAG;
                end
            end
            PH_TEXT:
            begin
                kind = KIND_TEXT;
                if (p_remaining != 0)
                    p_remaining = p_remaining - 1;
                if (p_remaining == 0)
                    p_phase = PH_TAG;
            end
            PH_PLEN:
            begin
                kind    = KIND_PLEN;
                p_acc   = {p_acc[23:0], b};
                p_count = p_count + 1'b1;
                if (p_count >= PLEN_BYTES)
                begin
                    p_saved     = p_acc;
                    p_remaining = p_acc;
                    p_phase     = (p_remaining != 0) ? PH_PAY : PH_TRAIL;
                end
            end
            PH_PAY:
            begin
                kind = KIND_PAYLOAD;
                if (p_remaining != 0)
                    p_remaining = p_remaining - 1;
                if (p_remaining == 0)
                    p_phase = PH_TRAIL;
            end
            PH_TRAIL:
                kind = KIND_TRAILING;
            default:
                kind = KIND_IGNORED;
        endcase

        // an error sticks until the end of the file
        if (err != STATUS_RUNNING)
        begin
            p_error = err;
            p_phase = PH_IGN;
        end

        if (p_error != STATUS_RUNNING)
            status = p_error;
        else if (in.last_byte)
        begin
            // end of file: the verdict depends on where the parser stands
            case (p_phase)
                PH_PRE:   status = STATUS_BAD_PREAMBLE;
                PH_TEXT:  status = STATUS_SECT_OVERRUN;
                PH_PAY:   status = STATUS_PAY_OVERRUN;
                PH_TRAIL: status = (kind == KIND_TRAILING) ? STATUS_DONE_TRAIL
                                                           : STATUS_DONE_OK;
                default:  status = STATUS_EARLY_END;
            endcase
        end
        else
            status = STATUS_RUNNING;

        res.byte_out       = b;
        res.byte_kind      = kind;
        res.section_index  = p_section;
        res.payload_length = p_saved;
        res.parse_status   = status;

        if (in.last_byte)
            clear_parse_state();
    endtask

    // queue a whole file, last flag on its final byte
    task automatic send_file(input byte_q_t fb);
        bsp_in_t one;
        for (int i = 0; i < fb.size(); i++)
        begin
            one.data_byte = fb[i];
            one.last_byte = (i == fb.size() - 1);
            file_bytes_pending.push_back(one);
            bytes_queued++;
        end
    endtask

    // mostly well-formed files with random content, the rest damaged or noise
    task automatic add_random_file();
        byte_q_t     fb;
        int unsigned tag_at[$];
        int unsigned n_sect;
        int unsigned slen;
        int unsigned plen;
        int unsigned n_body;
        int unsigned shape;
        int unsigned pick;
        logic        cut_open;
        cut_open = 1'b0;
        for (int i = 0; i < 13; i++)
            fb.push_back(FILE_PREAMBLE[i]);

        n_sect = $urandom_range(0, 4);
        for (int s = 0; s < n_sect && !cut_open; s++)
        begin
            tag_at.push_back(fb.size());
            fb.push_back(TAG_A + 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 19) == 0)
            begin
                // long section, file ends inside its text
                slen     = $urandom_range(256, 65535);
                cut_open = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
                slen = $urandom_range(0, 48);
            else
                slen = $urandom_range(0, 5);
            fb.push_back(8'(slen >> 8));
            fb.push_back(8'(slen));
            n_body = cut_open ? $urandom_range(0, 6) : slen;
            repeat (n_body) fb.push_back(8'($urandom));
        end

        if (!cut_open)
        begin
            tag_at.push_back(fb.size());
            fb.push_back(TAG_E);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // payload length too big to finish, file ends inside payload
                plen     = $urandom | 32'h100;
                cut_open = 1'b1;
            end
            else if (pick < 3)
                plen = $urandom_range(0, 60);
            else
                plen = $urandom_range(0, 8);
            for (int k = 3; k >= 0; k--)
                fb.push_back(8'(plen >> (8 * k)));
            n_body = cut_open ? $urandom_range(0, 6) : plen;
            repeat (n_body) fb.push_back(8'($urandom));
            if (!cut_open && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
        end

        shape = $urandom_range(0, 99);
        if (shape >= 90)
        begin
            // plain noise
            fb.delete();
            repeat ($urandom_range(1, 16)) fb.push_back(8'($urandom));
        end
        else if (shape >= 80)
        begin
            // damage one tag, maybe into another valid one
            pick     = tag_at[$urandom_range(0, tag_at.size() - 1)];
            fb[pick] = 8'($urandom);
        end
        else if (shape >= 70)
        begin
            // flip bits in one preamble byte
            pick     = $urandom_range(0, 12);
            fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
        end
        else if (shape >= 55)
        begin
            // file cut short at any byte
            pick = $urandom_range(1, fb.size());
            while (fb.size() > pick)
                fb.delete(fb.size() - 1);
        end
        send_file(fb);
    endtask

    // driver: presents the head of the pending queue, predicts on each transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        bsp_out_t predicted;
        logic     holding;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_wait  = 0;
            clear_parse_state();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                tag_byte(item, predicted);
                tagged_bytes_due.push_back(predicted);
                file_bytes_pending.delete(0);
                if ($urandom_range(0, 99) < 4)
                    send_steady = ~send_steady;
                send_wait = send_steady ? 0 : $urandom_range(0, 5);
                holding   = 1'b0;
            end
            else
                holding = item_valid;

            // a stalled byte stays put; otherwise idle or offer the next one
            if (!holding)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    item_valid <= 1'b0;
                end
                else if (file_bytes_pending.size() > 0)
                begin
                    item_valid <= 1'b1;
                    item       <= file_bytes_pending[0];
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each tagged byte against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : take_results
        bsp_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            take_wait    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (tagged_bytes_due.size() == 0)
                    report_mismatch($sformatf("result %h with nothing outstanding",
                                              result.byte_out));
                else
                begin
                    want = tagged_bytes_due[0];
                    tagged_bytes_due.delete(0);
                    if (result.byte_out !== want.byte_out)
                        report_mismatch($sformatf("byte_out %h, predicted %h",
                                                  result.byte_out, want.byte_out));
                    if (result.byte_kind !== want.byte_kind)
                        report_mismatch($sformatf("byte_kind %0d, predicted %0d (byte %h)",
                                                  result.byte_kind, want.byte_kind,
                                                  want.byte_out));
                    if (result.section_index !== want.section_index)
                        report_mismatch($sformatf("section_index %0d, predicted %0d",
                                                  result.section_index,
                                                  want.section_index));
                    if (result.payload_length !== want.payload_length)
                        report_mismatch($sformatf("payload_length %h, predicted %h",
                                                  result.payload_length,
                                                  want.payload_length));
                    if (result.parse_status !== want.parse_status)
                        report_mismatch($sformatf("parse_status %0d, predicted %0d (byte %h)",
                                                  result.parse_status, want.parse_status,
                                                  want.byte_out));
                end
                if ($urandom_range(0, 99) < 4)
                    take_steady = ~take_steady;
                take_wait = take_steady ? 0 : $urandom_range(0, 5);
            end

            if (take_wait > 0)
            begin
                take_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // watchdog: gives up when neither side has made a transfer for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_files
        byte_q_t fb;

        // directed files
        // file that ends on its very first byte, still inside the preamble
        fb.push_back(FILE_PREAMBLE[0]);
        send_file(fb);
        // wrong first byte that is also the last one
        fb.delete();
        fb.push_back(8'ha5);
        send_file(fb);
        // empty section d, then the largest payload length; the file ends
        // on the first payload byte
        fb.delete();
        for (int i = 0; i < 13; i++)
            fb.push_back(FILE_PREAMBLE[i]);
        fb.push_back(TAG_D);
        fb.push_back(8'h00);
        fb.push_back(8'h00);
        fb.push_back(TAG_E);
        repeat (4) fb.push_back(8'hff);
        fb.push_back(8'h3c);
        send_file(fb);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // hold off new files until the parser has answered everything
        while (file_bytes_pending.size() != 0 || item_valid ||
               tagged_bytes_due.size() != 0)
            @(posedge clk);

        // random files
        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES)
            add_random_file();

        while (file_bytes_pending.size() != 0 || item_valid ||
               tagged_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bsp_pkg.sv
rtl/bsp_step.sv
rtl/bitfile_section_parser_top.sv
dv/testbench.sv
